/* sv/imu_md_pkg.sv */
package imu_md_pkg;

  // Datapath widths
  localparam int unsigned OpW   = 33;         // multiplier operand
  localparam int unsigned ProdW = 2 * OpW;    // multiplier product
  localparam int unsigned AccW  = 100;        // holds any square or scaled sum
  localparam int unsigned PrdW  = 92;         // sum of squares times 5^12
  localparam int unsigned RootW = 49;         // threshold times interval
  localparam int unsigned ConfW = 26;         // confirm time in microseconds
  localparam int unsigned CmpW  = AccW + 4;
  localparam int unsigned PcW   = 5;

  // 10^12 = 5^12 * 2^12; the 2^12 factor is folded into the compare shifts
  localparam logic [31:0] GravityQ16 = 32'd642689;
  localparam logic [27:0] Pow5Of12   = 28'd244140625;
  localparam logic [9:0]  MsToUs     = 10'd1000;

  typedef struct packed {
    logic signed [31:0] ang_x;
    logic signed [31:0] ang_y;
    logic signed [31:0] ang_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [15:0]        ang_interval_us;
    logic [15:0]        vel_interval_us;
  } sample_t;

  typedef enum logic [3:0] {
    A_ZERO, A_MAG0, A_MAG1, A_MAG2, A_MAG3, A_MAG4, A_MAG5,
    A_ACC_LO, A_ACC_HI, A_ROOT_LO, A_ROOT_HI,
    A_GYRO_THR, A_G_PLUS_A, A_G_MINUS_A, A_CONF_MS
  } opa_e;

  typedef enum logic [2:0] {
    B_SAME, B_POW5, B_T_ANG, B_T_VEL, B_ROOT_HI, B_MS_TO_US
  } opb_e;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_e;
  typedef enum logic [1:0] {SH_0, SH_32, SH_33, SH_64} acc_sh_e;
  typedef enum logic [2:0] {STO_NONE, STO_PANG, STO_PVEL, STO_ROOT, STO_CONF} sto_e;
  typedef enum logic [1:0] {CMP_NONE, CMP_GYRO_HI, CMP_ACC_HI, CMP_ACC_LO} cmp_e;
  typedef enum logic [1:0] {JMP_NONE, JMP_SKIP, JMP_NO_LO} jmp_e;

  typedef struct packed {
    opa_e             opa;
    opb_e             opb;
    acc_op_e          acc_op;
    acc_sh_e          acc_sh;
    sto_e             sto;
    cmp_e             cmp;
    jmp_e             jmp;
    logic [PcW-1:0]   target;
    logic             last;
  } ucode_t;

  typedef struct packed {
    logic skip;    // latched or invalid sample: no evaluation
    logic no_lo;   // accel threshold reaches gravity: no lower bound test
  } seq_cond_t;

  typedef struct packed {
    logic             sample_valid;
    logic             seen;
    logic [ConfW-1:0] confirm_us;
  } dp_status_t;

  localparam logic [PcW-1:0] PcFinish = 5'd25;

  localparam ucode_t UcodeNop = '{
    opa: A_ZERO, opb: B_SAME, acc_op: ACC_HOLD, acc_sh: SH_0, sto: STO_NONE,
    cmp: CMP_NONE, jmp: JMP_NONE, target: '0, last: 1'b0
  };

  function automatic ucode_t uc(input opa_e a, input opb_e b, input acc_op_e op,
                                input acc_sh_e sh, input sto_e st, input cmp_e c,
                                input jmp_e j, input logic [PcW-1:0] tgt,
                                input logic last);
    ucode_t w;
    w.opa    = a;
    w.opb    = b;
    w.acc_op = op;
    w.acc_sh = sh;
    w.sto    = st;
    w.cmp    = c;
    w.jmp    = j;
    w.target = tgt;
    w.last   = last;
    return w;
  endfunction

  // Microprogram. The product of step n is consumed by the accumulator in step n+1.
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      // gyro: sum of squares, scale, square of threshold * interval
      5'd0:  w = uc(A_MAG0, B_SAME, ACC_HOLD, SH_0, STO_NONE, CMP_NONE, JMP_SKIP,
                    PcFinish, 1'b0);
      5'd1:  w = uc(A_MAG1, B_SAME, ACC_LOAD, SH_0, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd2:  w = uc(A_MAG2, B_SAME, ACC_ADD, SH_0, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd3:  w = uc(A_GYRO_THR, B_T_ANG, ACC_ADD, SH_0, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd4:  w = uc(A_ACC_LO, B_POW5, ACC_HOLD, SH_0, STO_ROOT, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd5:  w = uc(A_ACC_HI, B_POW5, ACC_LOAD, SH_0, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd6:  w = uc(A_ROOT_LO, B_SAME, ACC_ADD, SH_32, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd7:  w = uc(A_ROOT_LO, B_ROOT_HI, ACC_LOAD, SH_0, STO_PANG, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd8:  w = uc(A_ROOT_HI, B_SAME, ACC_ADD, SH_33, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd9:  w = uc(A_MAG3, B_SAME, ACC_ADD, SH_64, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      // accel: sum of squares, scale, upper bound
      5'd10: w = uc(A_MAG4, B_SAME, ACC_LOAD, SH_0, STO_NONE, CMP_GYRO_HI, JMP_NONE,
                    '0, 1'b0);
      5'd11: w = uc(A_MAG5, B_SAME, ACC_ADD, SH_0, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd12: w = uc(A_G_PLUS_A, B_T_VEL, ACC_ADD, SH_0, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd13: w = uc(A_ACC_LO, B_POW5, ACC_HOLD, SH_0, STO_ROOT, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd14: w = uc(A_ACC_HI, B_POW5, ACC_LOAD, SH_0, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd15: w = uc(A_ROOT_LO, B_SAME, ACC_ADD, SH_32, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd16: w = uc(A_ROOT_LO, B_ROOT_HI, ACC_LOAD, SH_0, STO_PVEL, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd17: w = uc(A_ROOT_HI, B_SAME, ACC_ADD, SH_33, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd18: w = uc(A_G_MINUS_A, B_T_VEL, ACC_ADD, SH_64, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd19: w = uc(A_CONF_MS, B_MS_TO_US, ACC_HOLD, SH_0, STO_ROOT, CMP_ACC_HI,
                    JMP_NO_LO, PcFinish, 1'b0);
      // accel lower bound
      5'd20: w = uc(A_ROOT_LO, B_SAME, ACC_HOLD, SH_0, STO_CONF, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd21: w = uc(A_ROOT_LO, B_ROOT_HI, ACC_LOAD, SH_0, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd22: w = uc(A_ROOT_HI, B_SAME, ACC_ADD, SH_33, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd23: w = uc(A_ZERO, B_SAME, ACC_ADD, SH_64, STO_NONE, CMP_NONE, JMP_NONE,
                    '0, 1'b0);
      5'd24: w = uc(A_ZERO, B_SAME, ACC_HOLD, SH_0, STO_NONE, CMP_ACC_LO, JMP_NONE,
                    '0, 1'b1);
      // finish: capture confirm time product when arriving by the jump from step 19
      5'd25: w = uc(A_ZERO, B_SAME, ACC_HOLD, SH_0, STO_CONF, CMP_NONE, JMP_NONE,
                    '0, 1'b1);
      default: w = uc(A_ZERO, B_SAME, ACC_HOLD, SH_0, STO_NONE, CMP_NONE, JMP_NONE,
                      '0, 1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

/* sv/imu_motion_detector_core.sv */
// IMU motion detector.
// Input stream: one IMU sample per transaction on s_axis (delta angles, delta
// velocities, both integration times, timestamp). Output stream: one status
// transaction per sample on m_axis (moving, sample valid, motion seen,
// candidate held). Thresholds and confirm time come in on the cfg write port;
// write them only while the block is idle.
// Timing: a sample runs through a microprogram of up to 25 steps on one shared
// 33x33 multiplier and a 100-bit accumulator. A full evaluation runs the most
// steps; fewer run when the accel threshold reaches gravity (no lower bound
// test) and fewest when the sample is invalid or motion is latched. The next
// sample is accepted the cycle after the result is loaded; no new sample is
// taken while one is being evaluated.
// The result sits in an output register: a stalled receiver does not block the
// next sample, but a finished sample waits (holding the detector state) until
// the previous result has been taken.
// Reset clears the moving latch and the motion candidate and loads the default
// thresholds (gyro 0.5 rad/s, accel 1 m/s^2, confirm 500 ms).
module imu_motion_detector_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // ang_x[31:0], ang_y[63:32], ang_z[95:64], vel_x[127:96], vel_y[159:128],
  // vel_z[191:160], ang_interval_us[207:192], vel_interval_us[223:208],
  // stamp_us[287:224]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  // moving[0], sample_valid[1], motion_seen[2], candidate_active[3], zero[7:4]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_e;

  typedef enum logic [1:0] {
    REG_GYRO_THR  = 2'd0,
    REG_ACCEL_THR = 2'd1,
    REG_CONFIRM   = 2'd2
  } cfg_reg_e;

  state_e      state_q;
  logic [31:0] gyro_thr_q, accel_thr_q;
  logic [15:0] confirm_ms_q;

  logic        moving_q, moving_d;
  logic        cand_valid_q, cand_valid_d;
  logic [63:0] cand_start_q, cand_start_d;
  logic [63:0] stamp_q;
  logic        m_valid_q;
  logic [7:0]  m_data_q;

  logic                      in_fire, out_free, seq_done;
  logic                      seen_out;
  logic [64:0]               elapsed;
  imu_md_pkg::sample_t       sample;
  imu_md_pkg::seq_cond_t     cond;
  imu_md_pkg::ucode_t        ctrl;
  imu_md_pkg::dp_status_t    dp_status;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Unpack the sample, lowest field in the lowest bits
  assign sample.ang_x           = s_axis_tdata[31:0];
  assign sample.ang_y           = s_axis_tdata[63:32];
  assign sample.ang_z           = s_axis_tdata[95:64];
  assign sample.vel_x           = s_axis_tdata[127:96];
  assign sample.vel_y           = s_axis_tdata[159:128];
  assign sample.vel_z           = s_axis_tdata[191:160];
  assign sample.ang_interval_us = s_axis_tdata[207:192];
  assign sample.vel_interval_us = s_axis_tdata[223:208];

  // Skip evaluation when latched or invalid; drop the lower accel bound when
  // the threshold reaches gravity
  assign cond.skip  = moving_q || !dp_status.sample_valid;
  assign cond.no_lo = (accel_thr_q >= imu_md_pkg::GravityQ16);

  imu_md_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .cond_i  (cond),
    .ctrl_o  (ctrl),
    .done_o  (seq_done)
  );

  imu_md_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_fire),
    .sample_i     (sample),
    .gyro_thr_i   (gyro_thr_q),
    .accel_thr_i  (accel_thr_q),
    .confirm_ms_i (confirm_ms_q),
    .ctrl_i       (ctrl),
    .status_o     (dp_status)
  );

  // Elapsed time since the candidate start; the top bit is the borrow, set
  // when time went backward
  assign elapsed  = {1'b0, stamp_q} - {1'b0, cand_start_q};
  assign seen_out = !moving_q && dp_status.sample_valid && dp_status.seen;

  // Candidate and latch update for the finished sample
  always_comb begin
    moving_d     = moving_q;
    cand_valid_d = cand_valid_q;
    cand_start_d = cand_start_q;
    if (!moving_q) begin
      if (!dp_status.sample_valid || !dp_status.seen) begin
        // drop the candidate
        cand_valid_d = 1'b0;
        cand_start_d = '0;
      end else if (!cand_valid_q) begin
        // open a candidate at this sample
        cand_valid_d = 1'b1;
        cand_start_d = stamp_q;
      end else if (!elapsed[64] &&
                   (elapsed[63:0] >= 64'(dp_status.confirm_us))) begin
        moving_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_thr_q   <= 32'd32768;
      accel_thr_q  <= 32'd65536;
      confirm_ms_q <= 16'd500;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GYRO_THR:  gyro_thr_q   <= cfg_data_i;
        REG_ACCEL_THR: accel_thr_q  <= cfg_data_i;
        REG_CONFIRM:   confirm_ms_q <= cfg_data_i[15:0];
        default: ;   // no register at this index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      moving_q     <= 1'b0;
      cand_valid_q <= 1'b0;
      cand_start_q <= '0;
      stamp_q      <= '0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
    end else begin
      // in S_FIN a taken result is replaced by the next one below
      if (m_valid_q && m_axis_tready && (state_q != S_FIN)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            stamp_q <= s_axis_tdata[287:224];
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (seq_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          // hold the result until the output register frees up
          if (out_free) begin
            moving_q     <= moving_d;
            cand_valid_q <= cand_valid_d;
            cand_start_q <= cand_start_d;
            m_valid_q    <= 1'b1;
            m_data_q     <= {4'b0000, cand_valid_d, seen_out,
                             dp_status.sample_valid, moving_d};
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_moving_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    moving_q |=> moving_q)
    else $error("moving latch cleared without reset");

  a_seen_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (!m_data_q[2] || m_data_q[1]))
    else $error("motion reported for an invalid sample");

  a_invalid_drops_candidate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_data_q[0] && !m_data_q[1]) |-> !m_data_q[3])
    else $error("candidate held after an invalid sample");

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |-> (state_q == S_RUN))
    else $error("microprogram finished outside a run");

endmodule

/* sv/imu_md_seq.sv */
module imu_md_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  imu_md_pkg::seq_cond_t  cond_i,
  output imu_md_pkg::ucode_t     ctrl_o,
  output logic                   done_o
);

  logic                         running_q;
  logic [imu_md_pkg::PcW-1:0]   pc_q;
  imu_md_pkg::ucode_t           word;
  logic                         taken;

  assign word = imu_md_pkg::ucode_rom(pc_q);

  always_comb begin
    unique case (word.jmp)
      imu_md_pkg::JMP_SKIP:  taken = cond_i.skip;
      imu_md_pkg::JMP_NO_LO: taken = cond_i.no_lo;
      default:               taken = 1'b0;
    endcase
  end

  assign ctrl_o = running_q ? word : imu_md_pkg::UcodeNop;
  assign done_o = running_q && word.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      pc_q      <= '0;
    end else if (start_i) begin
      running_q <= 1'b1;
      pc_q      <= '0;
    end else if (running_q) begin
      if (word.last) begin
        running_q <= 1'b0;
      end
      pc_q <= taken ? word.target : pc_q + 1'b1;
    end
  end

endmodule

/* sv/imu_md_dp.sv */
module imu_md_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  imu_md_pkg::sample_t   sample_i,
  input  logic [31:0]           gyro_thr_i,
  input  logic [31:0]           accel_thr_i,
  input  logic [15:0]           confirm_ms_i,
  input  imu_md_pkg::ucode_t    ctrl_i,
  output imu_md_pkg::dp_status_t status_o
);

  localparam int unsigned OpW   = imu_md_pkg::OpW;
  localparam int unsigned ProdW = imu_md_pkg::ProdW;
  localparam int unsigned AccW  = imu_md_pkg::AccW;
  localparam int unsigned PrdW  = imu_md_pkg::PrdW;
  localparam int unsigned RootW = imu_md_pkg::RootW;
  localparam int unsigned ConfW = imu_md_pkg::ConfW;
  localparam int unsigned CmpW  = imu_md_pkg::CmpW;

  logic [31:0]      mag_q [6];
  logic [15:0]      t_ang_q, t_vel_q;
  logic [ProdW-1:0] p_q;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [PrdW-1:0]  pang_q, pvel_q;
  logic [RootW-1:0] root_q;
  logic [ConfW-1:0] conf_q;
  logic             seen_q;

  logic [OpW-1:0]   op_a, op_b;
  logic [AccW-1:0]  p_ext, addend;
  logic [OpW-1:0]   g_plus_a, g_minus_a;
  logic             gyro_hi, acc_hi, acc_lo, hit;
  logic [CmpW-1:0]  pang_cmp, pvel_cmp, acc_cmp, acc_sh4;

  assign g_plus_a  = OpW'(imu_md_pkg::GravityQ16) + OpW'(accel_thr_i);
  assign g_minus_a = OpW'(imu_md_pkg::GravityQ16) - OpW'(accel_thr_i);

  always_comb begin
    unique case (ctrl_i.opa)
      imu_md_pkg::A_MAG0:      op_a = OpW'(mag_q[0]);
      imu_md_pkg::A_MAG1:      op_a = OpW'(mag_q[1]);
      imu_md_pkg::A_MAG2:      op_a = OpW'(mag_q[2]);
      imu_md_pkg::A_MAG3:      op_a = OpW'(mag_q[3]);
      imu_md_pkg::A_MAG4:      op_a = OpW'(mag_q[4]);
      imu_md_pkg::A_MAG5:      op_a = OpW'(mag_q[5]);
      imu_md_pkg::A_ACC_LO:    op_a = OpW'(acc_q[31:0]);
      imu_md_pkg::A_ACC_HI:    op_a = OpW'(acc_q[63:32]);
      imu_md_pkg::A_ROOT_LO:   op_a = OpW'(root_q[31:0]);
      imu_md_pkg::A_ROOT_HI:   op_a = OpW'(root_q[RootW-1:32]);
      imu_md_pkg::A_GYRO_THR:  op_a = OpW'(gyro_thr_i);
      imu_md_pkg::A_G_PLUS_A:  op_a = g_plus_a;
      imu_md_pkg::A_G_MINUS_A: op_a = g_minus_a;
      imu_md_pkg::A_CONF_MS:   op_a = OpW'(confirm_ms_i);
      default:                 op_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.opb)
      imu_md_pkg::B_POW5:     op_b = OpW'(imu_md_pkg::Pow5Of12);
      imu_md_pkg::B_T_ANG:    op_b = OpW'(t_ang_q);
      imu_md_pkg::B_T_VEL:    op_b = OpW'(t_vel_q);
      imu_md_pkg::B_ROOT_HI:  op_b = OpW'(root_q[RootW-1:32]);
      imu_md_pkg::B_MS_TO_US: op_b = OpW'(imu_md_pkg::MsToUs);
      default:                op_b = op_a;
    endcase
  end

  assign p_ext = AccW'(p_q);

  always_comb begin
    unique case (ctrl_i.acc_sh)
      imu_md_pkg::SH_32: addend = p_ext << 32;
      imu_md_pkg::SH_33: addend = p_ext << 33;
      imu_md_pkg::SH_64: addend = p_ext << 64;
      default:           addend = p_ext;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.acc_op)
      imu_md_pkg::ACC_LOAD: acc_d = addend;
      imu_md_pkg::ACC_ADD:  acc_d = acc_q + addend;
      default:              acc_d = acc_q;
    endcase
  end

  // Exact tests with the common 2^12 of 10^12 cancelled against the limit shifts
  assign pang_cmp = CmpW'(pang_q);
  assign pvel_cmp = CmpW'(pvel_q) << 4;
  assign acc_cmp  = CmpW'(acc_q);
  assign acc_sh4  = acc_cmp << 4;
  assign gyro_hi  = pang_cmp > acc_sh4;
  assign acc_hi   = pvel_cmp > acc_cmp;
  assign acc_lo   = pvel_cmp < acc_cmp;

  always_comb begin
    unique case (ctrl_i.cmp)
      imu_md_pkg::CMP_GYRO_HI: hit = gyro_hi;
      imu_md_pkg::CMP_ACC_HI:  hit = acc_hi;
      imu_md_pkg::CMP_ACC_LO:  hit = acc_lo;
      default:                 hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (load_i) begin
      seen_q <= 1'b0;
    end else if (hit) begin
      seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mag_q[0] <= imu_md_pkg::mag32(sample_i.ang_x);
      mag_q[1] <= imu_md_pkg::mag32(sample_i.ang_y);
      mag_q[2] <= imu_md_pkg::mag32(sample_i.ang_z);
      mag_q[3] <= imu_md_pkg::mag32(sample_i.vel_x);
      mag_q[4] <= imu_md_pkg::mag32(sample_i.vel_y);
      mag_q[5] <= imu_md_pkg::mag32(sample_i.vel_z);
      t_ang_q  <= sample_i.ang_interval_us;
      t_vel_q  <= sample_i.vel_interval_us;
    end
    p_q   <= op_a * op_b;
    acc_q <= acc_d;
    unique case (ctrl_i.sto)
      imu_md_pkg::STO_PANG: pang_q <= acc_q[PrdW-1:0];
      imu_md_pkg::STO_PVEL: pvel_q <= acc_q[PrdW-1:0];
      imu_md_pkg::STO_ROOT: root_q <= p_q[RootW-1:0];
      imu_md_pkg::STO_CONF: conf_q <= p_q[ConfW-1:0];
      default: ;
    endcase
  end

  assign status_o.sample_valid = (|t_ang_q) && (|t_vel_q);
  assign status_o.seen         = seen_q;
  assign status_o.confirm_us   = conf_q;

endmodule
